// File: hdl/fsp_pkg.sv
// Shared codes, field widths and controller/datapath interface types for the frame slot pool.
package fsp_pkg;

  // Field widths fixed by the command and result formats.
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;
  localparam int FRAME_W  = 48;
  localparam int DROP_W   = 32;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_STORE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ACQUIRED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd6;

  // Saturation limits.
  localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};
  localparam logic [DROP_W-1:0]  DROP_MAX  = {DROP_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic commit;
  } fsp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_hit;
    logic scan_last;
    logic out_busy;
  } fsp_stat_t;

endpackage

// File: hdl/fsp_ctrl.sv
// Controller state machine that sequences command capture, slot scan and result commit.
module fsp_ctrl import fsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_command_i,
  output logic             in_stall_o,
  input  fsp_stat_t        stat_i,
  output fsp_ctrl_t        ctrl_o
);

  localparam logic [1:0] STATE_IDLE = 2'd0;
  localparam logic [1:0] STATE_SCAN = 2'd1;
  localparam logic [1:0] STATE_EXEC = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;
  logic       scan_done;

  // New commands are taken only while no command is in progress.
  assign in_stall_o = (state_q != STATE_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign scan_done  = stat_i.scan_hit || stat_i.scan_last;

  // Next state and datapath commands.
  always_comb begin
    state_d          = state_q;
    ctrl_o.capture   = accept;
    ctrl_o.scan_step = 1'b0;
    ctrl_o.commit    = 1'b0;
    case (state_q)
      STATE_IDLE: begin
        if (accept) begin
          case (in_command_i)
            CMD_STORE:   state_d = STATE_SCAN;
            CMD_ACQUIRE: state_d = STATE_EXEC;
            CMD_RELEASE: state_d = STATE_EXEC;
            default:     state_d = STATE_IDLE;
          endcase
        end
      end
      STATE_SCAN: begin
        if (!scan_done) begin
          ctrl_o.scan_step = 1'b1;
        end else if (!stat_i.out_busy) begin
          ctrl_o.commit = 1'b1;
          state_d       = STATE_IDLE;
        end
      end
      STATE_EXEC: begin
        if (!stat_i.out_busy) begin
          ctrl_o.commit = 1'b1;
          state_d       = STATE_IDLE;
        end
      end
      default: state_d = STATE_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/fsp_datapath.sv
// Datapath holding the slot table, latest-frame state, drop counter and result register.
module fsp_datapath import fsp_pkg::*; #(
  parameter int SLOTS    = 4,
  parameter int REF_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CMD_W-1:0]    in_command_i,
  input  logic [SLOT_W-1:0]   in_release_slot_i,
  input  fsp_ctrl_t           ctrl_i,
  output fsp_stat_t           stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [SLOT_W-1:0]   out_slot_o,
  output logic [FRAME_W-1:0]  out_frame_number_o,
  output logic [DROP_W-1:0]   out_dropped_total_o
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [REF_BITS-1:0] REF_MAX  = {REF_BITS{1'b1}};

  // Slot table.
  logic                slot_ready_q [SLOTS];
  logic [REF_BITS-1:0] slot_refs_q  [SLOTS];
  logic [FRAME_W-1:0]  slot_frame_q [SLOTS];

  // Pool state.
  logic               latest_valid_q;
  logic [IDX_W-1:0]   latest_index_q;
  logic [FRAME_W-1:0] latest_frame_q;
  logic [DROP_W-1:0]  drop_count_q;

  // Captured transaction and scan position.
  logic [CMD_W-1:0]  cmd_q;
  logic [SLOT_W-1:0] rel_q;
  logic [IDX_W-1:0]  ptr_q;
  logic [IDX_W-1:0]  cnt_q;

  // Result register.
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [FRAME_W-1:0]  out_frame_q;
  logic [DROP_W-1:0]   out_drop_q;

  logic [IDX_W-1:0]    rd_idx;
  logic                rd_ready;
  logic [REF_BITS-1:0] rd_refs;
  logic [FRAME_W-1:0]  rd_frame;
  logic [FRAME_W-1:0]  next_frame;
  logic [DROP_W-1:0]   drop_inc;
  logic                rel_bad;
  logic                acq_ok;

  // The single table read port follows the command in progress.
  always_comb begin
    case (cmd_q)
      CMD_STORE:   rd_idx = ptr_q;
      CMD_ACQUIRE: rd_idx = latest_index_q;
      default:     rd_idx = rel_q[IDX_W-1:0];
    endcase
  end

  assign rd_ready = slot_ready_q[rd_idx];
  assign rd_refs  = slot_refs_q[rd_idx];
  assign rd_frame = slot_frame_q[rd_idx];

  // Saturating next frame number and drop count, and command checks.
  assign next_frame = (latest_frame_q == FRAME_MAX) ? FRAME_MAX : latest_frame_q + 1'b1;
  assign drop_inc   = (drop_count_q == DROP_MAX) ? DROP_MAX : drop_count_q + 1'b1;
  assign rel_bad    = (int'(rel_q) >= SLOTS);
  assign acq_ok     = latest_valid_q && (latest_frame_q != '0) && rd_ready
                      && (rd_frame == latest_frame_q);

  assign stat_o.scan_hit  = (rd_refs == '0);
  assign stat_o.scan_last = (cnt_q == LAST_IDX);
  assign stat_o.out_busy  = out_valid_q && out_stall_i;

  // Capture of the accepted transaction and the ring scan position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CMD_STORE;
      rel_q <= '0;
      ptr_q <= '0;
      cnt_q <= '0;
    end else if (ctrl_i.capture) begin
      cmd_q <= in_command_i;
      rel_q <= in_release_slot_i;
      cnt_q <= '0;
      if (!latest_valid_q) begin
        ptr_q <= '0;
      end else if (latest_index_q == LAST_IDX) begin
        ptr_q <= '0;
      end else begin
        ptr_q <= latest_index_q + 1'b1;
      end
    end else if (ctrl_i.scan_step) begin
      cnt_q <= cnt_q + 1'b1;
      ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
    end
  end

  // Slot table and pool state updates on commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_ready_q[i] <= 1'b0;
        slot_refs_q[i]  <= '0;
      end
      latest_valid_q <= 1'b0;
      latest_index_q <= '0;
      latest_frame_q <= '0;
      drop_count_q   <= '0;
    end else if (ctrl_i.commit) begin
      case (cmd_q)
        CMD_STORE: begin
          if (stat_o.scan_hit) begin
            slot_ready_q[rd_idx] <= 1'b1;
            latest_valid_q       <= 1'b1;
            latest_index_q       <= rd_idx;
            latest_frame_q       <= next_frame;
          end else begin
            drop_count_q <= drop_inc;
          end
        end
        CMD_ACQUIRE: begin
          if (acq_ok && rd_refs != REF_MAX) begin
            slot_refs_q[rd_idx] <= rd_refs + 1'b1;
          end
        end
        CMD_RELEASE: begin
          if (!rel_bad && rd_refs != '0) begin
            slot_refs_q[rd_idx] <= rd_refs - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Frame numbers held by the slots; read only once the slot has been stored.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && cmd_q == CMD_STORE && stat_o.scan_hit) begin
      slot_frame_q[rd_idx] <= next_frame;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      out_slot_q  <= '0;
      out_frame_q <= '0;
      out_drop_q  <= drop_count_q;
      case (cmd_q)
        CMD_STORE: begin
          if (stat_o.scan_hit) begin
            out_status_q <= ST_STORED;
            out_slot_q   <= SLOT_W'(rd_idx);
            out_frame_q  <= next_frame;
          end else begin
            out_status_q <= ST_DROPPED;
            out_drop_q   <= drop_inc;
          end
        end
        CMD_ACQUIRE: begin
          if (acq_ok) begin
            out_status_q <= ST_ACQUIRED;
            out_slot_q   <= SLOT_W'(rd_idx);
            out_frame_q  <= latest_frame_q;
          end else begin
            out_status_q <= ST_NONE;
          end
        end
        default: begin
          if (rel_bad) begin
            out_status_q <= ST_BAD_SLOT;
          end else if (rd_refs == '0) begin
            out_status_q <= ST_UNDERFLOW;
          end else begin
            out_status_q <= ST_RELEASED;
          end
        end
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_slot_o          = out_slot_q;
  assign out_frame_number_o  = out_frame_q;
  assign out_dropped_total_o = out_drop_q;

endmodule

// File: hdl/frame_slot_pool_manager.sv
// Top level of the reference-counted frame slot pool: controller plus datapath.
//
//   Channel  Dir  Handshake                 Fields
//   in       in   in_valid_i, in_stall_o    command, release_slot
//   out      out  out_valid_o, out_stall_i  status, slot, frame_number, dropped_total
//
// A store reads k slots in the ring scan (1 to SLOTS) before its result is registered;
// acquire and release register theirs without a scan.
// The next transaction can be taken once a result is registered, so transactions
// never overlap. Unknown commands are dropped at once.
// Reset clears the slot ready flags and reference counts, latest slot, frame number and drop counter at once.
// The input stalls while a transaction is in progress; a waiting result holds the
// commit of the next one until the output side takes it.
module frame_slot_pool_manager import fsp_pkg::*; #(
  parameter int SLOTS    = 4,
  parameter int REF_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    in_command_i,
  input  logic [SLOT_W-1:0]   in_release_slot_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [SLOT_W-1:0]   out_slot_o,
  output logic [FRAME_W-1:0]  out_frame_number_o,
  output logic [DROP_W-1:0]   out_dropped_total_o
);

  fsp_ctrl_t ctrl;
  fsp_stat_t stat;

  // Command sequencing.
  fsp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_command_i),
    .in_stall_o   (in_stall_o),
    .stat_i       (stat),
    .ctrl_o       (ctrl)
  );

  // Slot table and result register.
  fsp_datapath #(
    .SLOTS    (SLOTS),
    .REF_BITS (REF_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_command_i        (in_command_i),
    .in_release_slot_i   (in_release_slot_i),
    .ctrl_i              (ctrl),
    .stat_o              (stat),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_status_o        (out_status_o),
    .out_slot_o          (out_slot_o),
    .out_frame_number_o  (out_frame_number_o),
    .out_dropped_total_o (out_dropped_total_o)
  );

endmodule
